// ===== sv/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants for the three-class strict priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int CLASS_COUNT = 3;
  localparam int CLASS_W     = 2;
  localparam int TOTAL_W     = 6;
  localparam int CAP_W       = 5;
  localparam int IO_VALUE_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2,
    OP_SIZE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Response side-band that travels alongside the memory read.
  typedef struct packed {
    logic                valid;
    logic                use_data;
    status_e             status;
    logic [CLASS_W-1:0]  cls;
    logic [TOTAL_W-1:0]  total;
  } rsp_t;

endpackage

// ===== sv/tcpq_store.sv =====
// ----------------------------------------------------------------------------
// tcpq_store
// Entry storage for all three class queues: one address port shared by
// write and read, with a synchronous (registered) read.
// ----------------------------------------------------------------------------
module tcpq_store #(
  parameter int WORDS  = 48,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [WORDS];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tcpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Queue bookkeeping: head/tail pointers and fill counts per class, the
// capacity register, priority selection and memory request generation.
// ----------------------------------------------------------------------------
module tcpq_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int VALUE_BITS  = 32,
  parameter int ADDR_W      = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tcpq_pkg::CAP_W-1:0]          cfg_data_i,
  input  logic                                start_i,
  input  logic [1:0]                          opcode_i,
  input  logic [tcpq_pkg::CLASS_W-1:0]        class_id_i,
  input  logic [tcpq_pkg::IO_VALUE_W-1:0]     entry_value_i,
  output logic                                mem_we_o,
  output logic                                mem_re_o,
  output logic [ADDR_W-1:0]                   mem_addr_o,
  output logic [VALUE_BITS-1:0]               mem_wdata_o,
  output tcpq_pkg::rsp_t                      rsp_o
);
  import tcpq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int SUM_W = ((CNT_W + 2) > TOTAL_W) ? (CNT_W + 2) : TOTAL_W;

  logic [IDX_W-1:0] head_q [CLASS_COUNT];
  logic [IDX_W-1:0] head_d [CLASS_COUNT];
  logic [IDX_W-1:0] tail_q [CLASS_COUNT];
  logic [IDX_W-1:0] tail_d [CLASS_COUNT];
  logic [CNT_W-1:0] fill_q [CLASS_COUNT];
  logic [CNT_W-1:0] fill_d [CLASS_COUNT];
  logic [CAP_W-1:0] cap_q;
  rsp_t             rsp_q;
  rsp_t             rsp_d;

  logic [CMP_W-1:0]   eff_limit;
  logic               hp_found;
  logic [CLASS_W-1:0] hp_cls;
  logic               cls_ok;
  logic [SUM_W-1:0]   sum;
  op_e                op;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + IDX_W'(1);
    end
    return nxt;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLASS_W-1:0] cls,
                                                  input logic [IDX_W-1:0]   idx);
    logic [ADDR_W-1:0] base;
    case (cls)
      2'd0:    base = '0;
      2'd1:    base = ADDR_W'(QUEUE_DEPTH);
      default: base = ADDR_W'(2 * QUEUE_DEPTH);
    endcase
    return base + ADDR_W'(idx);
  endfunction

  assign op        = op_e'(opcode_i);
  assign eff_limit = (CMP_W'(cap_q) > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH)
                                                           : CMP_W'(cap_q);
  assign cls_ok    = class_id_i < CLASS_W'(CLASS_COUNT);

  // Lowest-numbered non-empty class wins.
  always_comb begin
    hp_found = 1'b0;
    hp_cls   = '0;
    for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
      if (fill_q[c] != '0) begin
        hp_found = 1'b1;
        hp_cls   = CLASS_W'(c);
      end
    end
  end

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = '0;
    mem_wdata_o = VALUE_BITS'(entry_value_i);
    rsp_d       = rsp_q;
    rsp_d.valid = 1'b0;
    sum         = '0;
    if (start_i) begin
      rsp_d.valid    = 1'b1;
      rsp_d.use_data = 1'b0;
      rsp_d.status   = ST_OK;
      rsp_d.cls      = '0;
      case (op)
        OP_ENQUEUE: begin
          if (!cls_ok) begin
            rsp_d.status = ST_FULL;
          end else if (CMP_W'(fill_q[class_id_i]) >= eff_limit) begin
            rsp_d.status = ST_FULL;
          end else begin
            mem_we_o           = 1'b1;
            mem_addr_o         = slot_addr(class_id_i, tail_q[class_id_i]);
            tail_d[class_id_i] = next_slot(tail_q[class_id_i]);
            fill_d[class_id_i] = fill_q[class_id_i] + CNT_W'(1);
          end
        end
        OP_DEQUEUE, OP_PEEK: begin
          if (!hp_found) begin
            rsp_d.status = ST_EMPTY;
          end else begin
            mem_re_o       = 1'b1;
            mem_addr_o     = slot_addr(hp_cls, head_q[hp_cls]);
            rsp_d.use_data = 1'b1;
            rsp_d.cls      = hp_cls;
            if (op == OP_DEQUEUE) begin
              head_d[hp_cls] = next_slot(head_q[hp_cls]);
              fill_d[hp_cls] = fill_q[hp_cls] - CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
      sum         = SUM_W'(fill_d[0]) + SUM_W'(fill_d[1]) + SUM_W'(fill_d[2]);
      rsp_d.total = sum[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        head_q[c] <= '0;
        tail_q[c] <= '0;
        fill_q[c] <= '0;
      end
      cap_q <= CAP_RESET;
      rsp_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
      rsp_q  <= rsp_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== sv/three_class_strict_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// three_class_strict_priority_queue_core
// Three FIFO queues, one per priority class, with enqueue, strict-priority
// dequeue, peek and total-size commands.
// ----------------------------------------------------------------------------
// Usage: a command is taken on every clock edge where start_i is high
// (busy_o stays low, so one command per cycle is sustained). The result
// appears in the next cycle with done_o high for that single cycle;
// there is no way to hold it off. The result is registered by the synchronous
// read of the entry memory, which holds 3*QUEUE_DEPTH values. An enqueue
// writes the memory in the cycle it is accepted, so a dequeue right behind
// it already sees the new entry. total_count_o reports the total after the
// command and keeps that value until the next result. capacity_limit
// (cfg_we_i / cfg_data_i) resets to 16 and is clipped to QUEUE_DEPTH.
// ----------------------------------------------------------------------------
module three_class_strict_priority_queue_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tcpq_pkg::CAP_W-1:0]         cfg_data_i,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         opcode_i,
  input  logic [tcpq_pkg::CLASS_W-1:0]       class_id_i,
  input  logic [tcpq_pkg::IO_VALUE_W-1:0]    entry_value_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [tcpq_pkg::IO_VALUE_W-1:0]    out_value_o,
  output logic [tcpq_pkg::CLASS_W-1:0]       out_class_o,
  output logic [tcpq_pkg::TOTAL_W-1:0]       total_count_o
);
  import tcpq_pkg::*;

  localparam int WORDS  = CLASS_COUNT * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(WORDS);

  logic                  mem_we;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_addr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic [VALUE_BITS-1:0] mem_rdata;
  rsp_t                  rsp;

  tcpq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .VALUE_BITS  (VALUE_BITS),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .start_i       (start_i),
    .opcode_i      (opcode_i),
    .class_id_i    (class_id_i),
    .entry_value_i (entry_value_i),
    .mem_we_o      (mem_we),
    .mem_re_o      (mem_re),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .rsp_o         (rsp)
  );

  tcpq_store #(
    .WORDS  (WORDS),
    .WIDTH  (VALUE_BITS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Commands are never stalled: busy_o is tied low.
  assign busy_o        = 1'b0;
  assign done_o        = rsp.valid;
  assign status_o      = rsp.status;
  assign out_class_o   = rsp.cls;
  assign total_count_o = rsp.total;
  assign out_value_o   = rsp.use_data ? IO_VALUE_W'(mem_rdata) : '0;

  // Each accepted transaction yields a result in the next cycle.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted transaction produced no result");

  // A successful enqueue raises the total by exactly one.
  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i == OP_ENQUEUE) |=>
      (status_o == ST_FULL) ||
      (total_count_o == $past(total_count_o) + TOTAL_W'(1)))
    else $error("enqueue total mismatch");

  // A successful dequeue lowers the total by exactly one.
  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i == OP_DEQUEUE) |=>
      (status_o == ST_EMPTY) ||
      (total_count_o == $past(total_count_o) - TOTAL_W'(1)))
    else $error("dequeue total mismatch");

  // Failed commands return no data.
  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (out_value_o == '0 && out_class_o == '0))
    else $error("failed transaction returned data");

endmodule

// ===== verif/three_class_strict_priority_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// three_class_strict_priority_queue_core_tb
// Drives enqueue, dequeue, peek and size commands with random gaps across a
// range of capacity limits, and checks every result against a transaction-level
// model of the three class queues held in a small scoreboard.
// ----------------------------------------------------------------------------
module three_class_strict_priority_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int NPHASES     = 9;
  localparam int PHASE_ITEMS = 148;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    status_e                status;
    logic [IO_VALUE_W-1:0]  value;
    logic [CLASS_W-1:0]     cls;
    logic [TOTAL_W-1:0]     total;
  } qresult_t;

  // Per-class circular buffers mirrored at transaction level.
  class tcpq_scoreboard;
    logic [IO_VALUE_W-1:0] slots [CLASS_COUNT][DEPTH];
    int unsigned           head_idx [CLASS_COUNT];
    int unsigned           tail_idx [CLASS_COUNT];
    int unsigned           fill [CLASS_COUNT];
    int unsigned           limit;
    qresult_t              awaiting [$];
    int unsigned           bad_count;

    function new();
      limit     = CAP_RESET;
      bad_count = 0;
      foreach (fill[k]) begin
        head_idx[k] = 0;
        tail_idx[k] = 0;
        fill[k]     = 0;
      end
    endfunction

    function void flag(string msg);
      bad_count++;
      if (bad_count <= MAX_REPORTS) begin
        $display("ERROR @%0t: %s", $time, msg);
      end
    endfunction

    function void note_command(op_e op, logic [CLASS_W-1:0] cls,
                               logic [IO_VALUE_W-1:0] val);
      qresult_t    r;
      int          top;
      int unsigned cap;
      r.status = ST_OK;
      r.value  = '0;
      r.cls    = '0;
      cap = (limit > DEPTH) ? DEPTH : limit;
      top = -1;
      for (int k = CLASS_COUNT - 1; k >= 0; k--) begin
        if (fill[k] != 0) top = k;
      end
      case (op)
        OP_ENQUEUE: begin
          if (cls >= CLASS_COUNT) begin
            r.status = ST_FULL;
          end else if (fill[cls] >= cap) begin
            r.status = ST_FULL;
          end else begin
            slots[cls][tail_idx[cls]] = val;
            tail_idx[cls] = (tail_idx[cls] + 1) % DEPTH;
            fill[cls]++;
          end
        end
        OP_DEQUEUE, OP_PEEK: begin
          if (top < 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.value = slots[top][head_idx[top]];
            r.cls   = CLASS_W'(top);
            if (op == OP_DEQUEUE) begin
              head_idx[top] = (head_idx[top] + 1) % DEPTH;
              fill[top]--;
            end
          end
        end
        default: ;
      endcase
      r.total = TOTAL_W'(fill[0] + fill[1] + fill[2]);
      awaiting.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [IO_VALUE_W-1:0] val,
                               logic [CLASS_W-1:0] cls, logic [TOTAL_W-1:0] tot);
      qresult_t e;
      if (awaiting.size() == 0) begin
        flag($sformatf("result with nothing outstanding: status %0d value %08h",
                       st, val));
      end else begin
        e = awaiting.pop_front();
        if (st != e.status)
          flag($sformatf("status expected %0d got %0d", e.status, st));
        if (val != e.value)
          flag($sformatf("out_value expected %08h got %08h", e.value, val));
        if (cls != e.cls)
          flag($sformatf("out_class expected %0d got %0d", e.cls, cls));
        if (tot != e.total)
          flag($sformatf("total_count expected %0d got %0d", e.total, tot));
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CAP_W-1:0]      cfg_data_i;
  logic                  start_i;
  logic                  busy_o;
  logic [1:0]            opcode_i;
  logic [CLASS_W-1:0]    class_id_i;
  logic [IO_VALUE_W-1:0] entry_value_i;
  logic                  done_o;
  logic [1:0]            status_o;
  logic [IO_VALUE_W-1:0] out_value_o;
  logic [CLASS_W-1:0]    out_class_o;
  logic [TOTAL_W-1:0]    total_count_o;

  int             quiet_cycles = 0;
  int             phase_limit [NPHASES] = '{31, 3, 16, 0, 1, 20, 9, 2, 16};
  tcpq_scoreboard sb = new();

  three_class_strict_priority_queue_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .class_id_i    (class_id_i),
    .entry_value_i (entry_value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .out_value_o   (out_value_o),
    .out_class_o   (out_class_o),
    .total_count_o (total_count_o)
  );

  always #4 clk_i = ~clk_i;

  // Result checked before the command of the same edge is noted: the result
  // belongs to the previous transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(status_o, out_value_o, out_class_o, total_count_o);
      if (cfg_we_i) sb.limit = cfg_data_i;
      if (start_i && !busy_o) sb.note_command(op_e'(opcode_i), class_id_i, entry_value_i);
      quiet_cycles <= (done_o || (start_i && !busy_o)) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("FAIL three_class_strict_priority_queue_core");
    $finish;
  end

  task automatic issue(op_e op, logic [CLASS_W-1:0] cls, logic [IO_VALUE_W-1:0] val);
    @(negedge clk_i);
    start_i       <= 1'b1;
    opcode_i      <= op;
    class_id_i    <= cls;
    entry_value_i <= val;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_burst(int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i       <= 1'b0;
      opcode_i      <= 2'($urandom);
      class_id_i    <= CLASS_W'($urandom);
      entry_value_i <= $urandom;
    end
  endtask

  // Sender holds off until every outstanding result is back.
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.awaiting.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [CAP_W-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic random_command(int enq_pct);
    op_e                   op;
    logic [CLASS_W-1:0]    cls;
    logic [IO_VALUE_W-1:0] val;
    int                    pick;
    if ($urandom_range(99) < enq_pct) begin
      op = OP_ENQUEUE;
    end else begin
      pick = $urandom_range(9);
      op = (pick < 6) ? OP_DEQUEUE : (pick < 8) ? OP_PEEK : OP_SIZE;
    end
    cls = ($urandom_range(19) == 0) ? CLASS_W'(3) : CLASS_W'($urandom_range(2));
    case ($urandom_range(7))
      0:       val = '0;
      1:       val = '1;
      default: val = $urandom;
    endcase
    issue(op, cls, val);
  endtask

  initial begin : stimulus
    int enq_pct;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = '0;
    start_i       = 1'b0;
    opcode_i      = OP_ENQUEUE;
    class_id_i    = '0;
    entry_value_i = '0;
    enq_pct       = 50;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty queues, bad class, priority order across all three classes
    issue(OP_DEQUEUE, 0, 0);
    issue(OP_PEEK, 0, 0);
    issue(OP_SIZE, 0, 0);
    issue(OP_ENQUEUE, 3, 32'h1234_5678);
    issue(OP_ENQUEUE, 2, 32'hA5A5_A5A5);
    issue(OP_ENQUEUE, 1, 32'hFFFF_FFFF);
    issue(OP_ENQUEUE, 0, 32'h0000_0000);
    issue(OP_PEEK, 0, 0);
    issue(OP_DEQUEUE, 0, 0);
    issue(OP_DEQUEUE, 0, 0);
    issue(OP_PEEK, 0, 0);
    issue(OP_DEQUEUE, 0, 0);
    issue(OP_DEQUEUE, 0, 0);
    issue(OP_SIZE, 0, 0);

    // zero limit: everything full
    write_limit(0);
    issue(OP_ENQUEUE, 1, 32'h5A5A_5A5A);
    issue(OP_SIZE, 0, 0);

    write_limit(2);
    issue(OP_ENQUEUE, 0, 32'h0000_0001);
    issue(OP_ENQUEUE, 0, 32'h8000_0000);
    issue(OP_ENQUEUE, 0, 32'hDEAD_BEEF);

    // limit dropped below current fill
    write_limit(1);
    issue(OP_ENQUEUE, 0, 32'h0F0F_0F0F);
    issue(OP_PEEK, 0, 0);
    issue(OP_DEQUEUE, 0, 0);
    issue(OP_ENQUEUE, 0, 32'hF0F0_F0F0);
    issue(OP_DEQUEUE, 0, 0);
    issue(OP_ENQUEUE, 0, 32'h7FFF_FFFF);

    for (int p = 0; p < NPHASES; p++) begin
      write_limit(CAP_W'(phase_limit[p]));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // switch at random between fill-heavy, drain-heavy and balanced stretches
        if (i % 32 == 0) begin
          case ($urandom_range(2))
            0:       enq_pct = 80;
            1:       enq_pct = 25;
            default: enq_pct = 55;
          endcase
        end
        if (p < NPHASES - 1 && $urandom_range(99) < 15) idle_burst($urandom_range(1, 8));
        random_command(enq_pct);
      end
    end

    drain();
    if (sb.awaiting.size() != 0) sb.flag("results still outstanding at end of run");
    if (sb.bad_count == 0) begin
      $display("PASS three_class_strict_priority_queue_core");
    end else begin
      $display("FAIL three_class_strict_priority_queue_core");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tcpq_pkg.sv
sv/tcpq_store.sv
sv/tcpq_ctrl.sv
sv/three_class_strict_priority_queue_core.sv
verif/three_class_strict_priority_queue_core_tb.sv
